// ----- rtl/psseq_pkg.sv -----
// ----------------------------------------------------------------------------
// psseq_pkg
// Shared types, constants and helpers for the probabilistic step sequencer.
// ----------------------------------------------------------------------------
package psseq_pkg;

  localparam int unsigned STEPS      = 16;
  localparam int unsigned DIVIDE_MAX = 16;

  localparam int unsigned DIV_W   = 5;   // divider register width
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned CNT_W   = 4;   // edge counter
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned LEN_W   = 5;   // length 1..STEPS
  localparam int unsigned CHANCE_W = 27;
  localparam int unsigned SHIFT_W = 7;
  localparam int unsigned PROB_W  = 25;  // clamped probability 0..one
  localparam int unsigned NUM_W   = 32;  // remainder unit dividend
  localparam int unsigned NBITS_W = 6;   // remainder unit iteration count
  localparam int unsigned SHORT_W = 6;   // short dividend for step wrap

  localparam logic [PROB_W-1:0] ONE_Q24 = PROB_W'(16777216);

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED    = 3'd4;

  localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd0;
  localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RANDOM  = 2'd2;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic [DIV_W-1:0]  div_a;
    logic [DIV_W-1:0]  div_b;
    logic [DIR_W-1:0]  dir_a;
    logic [DIR_W-1:0]  dir_b;
    logic              seed_load;
    logic [SEED_W-1:0] seed;
  } cfg_t;

  typedef struct packed {
    logic                       edge_a;
    logic                       edge_b;
    logic signed [CHANCE_W-1:0] chance_a;
    logic signed [CHANCE_W-1:0] chance_b;
    logic signed [SHIFT_W-1:0]  length_shift_a;
    logic signed [SHIFT_W-1:0]  length_shift_b;
  } item_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_a;
    logic [STEP_W-1:0] step_b;
    logic              moved_a;
    logic              moved_b;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;   // MSB-aligned
    logic [NBITS_W-1:0] nbits;
    logic [LEN_W-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] remainder;
  } rem_rsp_t;

  function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// ----- rtl/psseq_rem.sv -----
// ----------------------------------------------------------------------------
// psseq_rem
// Serial restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module psseq_rem (
  input  logic                rst_ni,
  input  logic                clk_i,
  input  psseq_pkg::rem_req_t req_i,
  output psseq_pkg::rem_rsp_t rsp_o
);

  logic [psseq_pkg::NUM_W-1:0]   num_q;
  logic [psseq_pkg::LEN_W-1:0]   den_q;
  logic [psseq_pkg::LEN_W-1:0]   rem_q;
  logic [psseq_pkg::LEN_W-1:0]   rem_d;
  logic [psseq_pkg::NBITS_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [psseq_pkg::LEN_W:0]     trial;

  // partial remainder stays below the divisor, so the shifted value fits LEN_W+1
  assign trial = {rem_q, num_q[psseq_pkg::NUM_W-1]};

  always_comb begin
    if (trial >= {1'b0, den_q}) begin
      rem_d = psseq_pkg::LEN_W'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[psseq_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.nbits;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == psseq_pkg::NBITS_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[psseq_pkg::NUM_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- rtl/psseq_ctrl.sv -----
// ----------------------------------------------------------------------------
// psseq_ctrl
// Sequencer: walks voice A then voice B through divider, draw and step update,
// borrowing the serial remainder unit for every wrap.
// ----------------------------------------------------------------------------
module psseq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psseq_pkg::cfg_t     cfg_i,
  input  logic                item_valid_i,
  input  psseq_pkg::item_t    item_i,
  output logic                item_ready_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output psseq_pkg::res_t     res_o,
  output psseq_pkg::rem_req_t rem_req_o,
  input  psseq_pkg::rem_rsp_t rem_rsp_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_VOICE = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_RAND  = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       voice_q, voice_d;

  psseq_pkg::item_t item_q;

  logic [psseq_pkg::STEP_W-1:0] step_q [2];
  logic [psseq_pkg::STEP_W-1:0] step_d [2];
  logic [psseq_pkg::CNT_W-1:0]  cnt_q  [2];
  logic [psseq_pkg::CNT_W-1:0]  cnt_d  [2];
  logic [1:0]                   moved_q, moved_d;
  logic [psseq_pkg::SEED_W-1:0] rand_q, rand_d, rand_nx;

  // per-voice selection
  logic                                 v_edge;
  logic signed [psseq_pkg::CHANCE_W-1:0] v_chance;
  logic signed [psseq_pkg::SHIFT_W-1:0]  v_shift;
  logic [psseq_pkg::DIV_W-1:0]          v_div_raw, v_div;
  logic [psseq_pkg::DIR_W-1:0]          v_dir;
  logic [psseq_pkg::STEP_W-1:0]         v_step;
  logic [psseq_pkg::CNT_W:0]            cnt_inc;
  logic signed [psseq_pkg::SHIFT_W:0]   len_sum;
  logic [psseq_pkg::LEN_W-1:0]          v_len;
  logic [psseq_pkg::PROB_W-1:0]         v_prob;
  logic                                 hit;
  logic [psseq_pkg::SHORT_W-1:0]        short_num;

  assign v_edge    = voice_q ? item_q.edge_b : item_q.edge_a;
  assign v_chance  = voice_q ? item_q.chance_b : item_q.chance_a;
  assign v_shift   = voice_q ? item_q.length_shift_b : item_q.length_shift_a;
  assign v_div_raw = voice_q ? cfg_i.div_b : cfg_i.div_a;
  assign v_dir     = voice_q ? cfg_i.dir_b : cfg_i.dir_a;
  assign v_step    = step_q[voice_q];
  assign cnt_inc   = {1'b0, cnt_q[voice_q]} + 1'b1;
  assign rand_nx   = psseq_pkg::xorshift32(rand_q);

  always_comb begin
    if (v_div_raw == '0) begin
      v_div = psseq_pkg::DIV_W'(1);
    end else if (v_div_raw > psseq_pkg::DIV_W'(psseq_pkg::DIVIDE_MAX)) begin
      v_div = psseq_pkg::DIV_W'(psseq_pkg::DIVIDE_MAX);
    end else begin
      v_div = v_div_raw;
    end
  end

  // length = clamp(STEPS + shift, 1, STEPS)
  assign len_sum = $signed((psseq_pkg::SHIFT_W+1)'(psseq_pkg::STEPS)) +
                   $signed({v_shift[psseq_pkg::SHIFT_W-1], v_shift});

  always_comb begin
    if (len_sum < $signed((psseq_pkg::SHIFT_W+1)'(1))) begin
      v_len = psseq_pkg::LEN_W'(1);
    end else if (len_sum > $signed((psseq_pkg::SHIFT_W+1)'(psseq_pkg::STEPS))) begin
      v_len = psseq_pkg::LEN_W'(psseq_pkg::STEPS);
    end else begin
      v_len = len_sum[psseq_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    if (v_chance[psseq_pkg::CHANCE_W-1]) begin
      v_prob = '0;
    end else if (v_chance[psseq_pkg::CHANCE_W-2:0] >
                 (psseq_pkg::CHANCE_W-1)'(psseq_pkg::ONE_Q24)) begin
      v_prob = psseq_pkg::ONE_Q24;
    end else begin
      v_prob = v_chance[psseq_pkg::PROB_W-1:0];
    end
  end

  assign hit = {1'b0, rand_nx[psseq_pkg::SEED_W-1:8]} < v_prob;

  // reverse wraps s + len - 1, forward wraps s + 1; both below 2^SHORT_W
  always_comb begin
    if (v_dir == psseq_pkg::DIR_REVERSE) begin
      short_num = psseq_pkg::SHORT_W'({2'b0, v_step}) + psseq_pkg::SHORT_W'(v_len) -
                  psseq_pkg::SHORT_W'(1);
    end else begin
      short_num = psseq_pkg::SHORT_W'({2'b0, v_step}) + psseq_pkg::SHORT_W'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    voice_d   = voice_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    moved_d   = moved_q;
    rand_d    = rand_q;
    rem_req_o = '0;
    rem_req_o.divisor = v_len;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          voice_d = 1'b0;
          moved_d = '0;
          state_d = ST_VOICE;
        end
      end
      ST_VOICE: begin
        if (!v_edge) begin
          moved_d[voice_q] = 1'b0;
          state_d = voice_q ? ST_DONE : ST_VOICE;
          voice_d = 1'b1;
        end else if ({1'b0, cnt_inc} < {1'b0, v_div}) begin
          cnt_d[voice_q]   = cnt_inc[psseq_pkg::CNT_W-1:0];
          moved_d[voice_q] = 1'b0;
          state_d = voice_q ? ST_DONE : ST_VOICE;
          voice_d = 1'b1;
        end else begin
          cnt_d[voice_q]   = '0;
          moved_d[voice_q] = 1'b1;
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        rand_d = rand_nx;
        if (!hit) begin
          state_d = voice_q ? ST_DONE : ST_VOICE;
          voice_d = 1'b1;
        end else if (v_dir == psseq_pkg::DIR_RANDOM) begin
          state_d = ST_RAND;
        end else begin
          rem_req_o.start    = 1'b1;
          rem_req_o.dividend = {short_num, (psseq_pkg::NUM_W-psseq_pkg::SHORT_W)'(0)};
          rem_req_o.nbits    = psseq_pkg::NBITS_W'(psseq_pkg::SHORT_W);
          state_d = ST_MOD;
        end
      end
      ST_RAND: begin
        rand_d             = rand_nx;
        rem_req_o.start    = 1'b1;
        rem_req_o.dividend = rand_nx;
        rem_req_o.nbits    = psseq_pkg::NBITS_W'(psseq_pkg::NUM_W);
        state_d = ST_MOD;
      end
      ST_MOD: begin
        if (rem_rsp_i.done) begin
          step_d[voice_q] = rem_rsp_i.remainder[psseq_pkg::STEP_W-1:0];
          state_d = voice_q ? ST_DONE : ST_VOICE;
          voice_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_i.seed_load) begin
      rand_d = (cfg_i.seed == '0) ? psseq_pkg::SEED_W'(1) : cfg_i.seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      voice_q  <= 1'b0;
      step_q   <= '{default: '0};
      cnt_q    <= '{default: '0};
      moved_q  <= '0;
      rand_q   <= psseq_pkg::SEED_W'(1);
    end else begin
      state_q  <= state_d;
      voice_q  <= voice_d;
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      moved_q  <= moved_d;
      rand_q   <= rand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i) begin
      item_q <= item_i;
    end
  end

  assign item_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o   = (state_q == ST_DONE);
  assign res_o.step_a  = step_q[0];
  assign res_o.step_b  = step_q[1];
  assign res_o.moved_a = moved_q[0];
  assign res_o.moved_b = moved_q[1];

endmodule

// ----- rtl/probabilistic_step_sequencer.sv -----
// ----------------------------------------------------------------------------
// probabilistic_step_sequencer
// Flow: an accepted tick passes ST_VOICE for voice A, then for voice B; a voice
//   that passes its divider goes through ST_DRAW, then on a hit ST_MOD (a serial
//   remainder in psseq_rem), with ST_RAND first for a random step; then ST_DONE and the output word register.
// Ticks: one at a time, the next accepted only once the last has left ST_DONE for
//   idle; a stalled output word holds the next tick back.
// Reset: steps and edge counters clear, generator loads 1, registers take
//   their reset values; no clearing pass.
// ----------------------------------------------------------------------------
module probabilistic_step_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [psseq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [psseq_pkg::SEED_W-1:0]         cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // edge_a, edge_b, chance_a, chance_b, length_shift_a, length_shift_b, zero pad
  input  logic [psseq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // step_a, step_b, moved_a, moved_b, zero pad
  output logic [psseq_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  logic [psseq_pkg::DIV_W-1:0] div_a_q, div_b_q;
  logic [psseq_pkg::DIR_W-1:0] dir_a_q, dir_b_q;

  psseq_pkg::cfg_t     cfg;
  psseq_pkg::item_t    item;
  psseq_pkg::res_t     res;
  psseq_pkg::res_t     out_q;
  psseq_pkg::rem_req_t rem_req;
  psseq_pkg::rem_rsp_t rem_rsp;
  logic                res_valid, res_ready;
  logic                out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_a_q <= psseq_pkg::DIV_W'(1);
      div_b_q <= psseq_pkg::DIV_W'(1);
      dir_a_q <= psseq_pkg::DIR_FORWARD;
      dir_b_q <= psseq_pkg::DIR_FORWARD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psseq_pkg::CFG_DIVIDER_A:   div_a_q <= cfg_data_i[psseq_pkg::DIV_W-1:0];
        psseq_pkg::CFG_DIVIDER_B:   div_b_q <= cfg_data_i[psseq_pkg::DIV_W-1:0];
        psseq_pkg::CFG_DIRECTION_A: dir_a_q <= cfg_data_i[psseq_pkg::DIR_W-1:0];
        psseq_pkg::CFG_DIRECTION_B: dir_b_q <= cfg_data_i[psseq_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // seed goes straight into the generator
  assign cfg.div_a     = div_a_q;
  assign cfg.div_b     = div_b_q;
  assign cfg.dir_a     = dir_a_q;
  assign cfg.dir_b     = dir_b_q;
  assign cfg.seed_load = cfg_we_i && (cfg_idx_i == psseq_pkg::CFG_RNG_SEED);
  assign cfg.seed      = cfg_data_i;

  assign item.edge_a         = s_axis_tdata[0];
  assign item.edge_b         = s_axis_tdata[1];
  assign item.chance_a       = s_axis_tdata[28:2];
  assign item.chance_b       = s_axis_tdata[55:29];
  assign item.length_shift_a = s_axis_tdata[62:56];
  assign item.length_shift_b = s_axis_tdata[69:63];

  psseq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (s_axis_tvalid),
    .item_i       (item),
    .item_ready_o (s_axis_tready),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .rem_req_o    (rem_req),
    .rem_rsp_i    (rem_rsp)
  );

  psseq_rem u_rem (
    .rst_ni (rst_ni),
    .clk_i  (clk_i),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // output word register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.moved_b, out_q.moved_a, out_q.step_b, out_q.step_a};

endmodule

// ----- bench/probabilistic_step_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// probabilistic_step_sequencer_tb
// Self-checking bench for the two-voice step sequencer. Ticks go in on the
// slave stream, and a model of the dividers, the shared xorshift generator and
// the step movement predicts every output word. Register settings change
// between phases, and the stream sides stall at random until the quiet tail.
// ----------------------------------------------------------------------------
module probabilistic_step_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psseq_pkg::*;

  // Direction code with no name in the package; the block runs it forward.
  localparam logic [DIR_W-1:0] DIR_SPARE  = 2'd3;
  localparam int unsigned      PHASE_TICKS = 275;
  localparam int               ONE         = 1 << 24;

  class step_scoreboard;
    logic [DIV_W-1:0]  divider [2];
    logic [DIR_W-1:0]  direction [2];
    logic [SEED_W-1:0] rng;
    int unsigned       step [2];
    int unsigned       edge_cnt [2];
    res_t              expected_steps [$];
    int                mismatches;

    function new();
      divider    = '{5'd1, 5'd1};
      direction  = '{DIR_FORWARD, DIR_FORWARD};
      rng        = 32'd1;
      step       = '{0, 0};
      edge_cnt   = '{0, 0};
      mismatches = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [SEED_W-1:0] data);
      case (idx)
        CFG_DIVIDER_A:   divider[0]   = data[DIV_W-1:0];
        CFG_DIVIDER_B:   divider[1]   = data[DIV_W-1:0];
        CFG_DIRECTION_A: direction[0] = data[DIR_W-1:0];
        CFG_DIRECTION_B: direction[1] = data[DIR_W-1:0];
        CFG_RNG_SEED:    rng          = (data == '0) ? 32'd1 : data;
        default: ;
      endcase
    endfunction

    function logic [SEED_W-1:0] next_random();
      logic [SEED_W-1:0] x;
      x   = rng;
      x   = x ^ (x << 13);
      x   = x ^ (x >> 17);
      x   = x ^ (x << 5);
      rng = x;
      return x;
    endfunction

    // Returns whether the voice got past its divider on this tick.
    function bit advance_voice(input int v, input logic edge_seen,
                               input logic signed [CHANCE_W-1:0] chance,
                               input logic signed [SHIFT_W-1:0] shift);
      int unsigned       div;
      int unsigned       len;
      int                span;
      int                prob;
      logic [SEED_W-1:0] r;
      if (!edge_seen) return 1'b0;
      div = 32'(divider[v]);
      if (div < 1) div = 1;
      if (div > DIVIDE_MAX) div = DIVIDE_MAX;
      edge_cnt[v]++;
      if (edge_cnt[v] < div) return 1'b0;
      edge_cnt[v] = 0;
      span = int'(STEPS) + int'(shift);
      if (span < 1) span = 1;
      if (span > int'(STEPS)) span = int'(STEPS);
      len  = span;
      prob = int'(chance);
      if (prob < 0) prob = 0;
      if (prob > ONE) prob = ONE;
      // draw is taken even when prob is zero
      r = next_random();
      if (int'(r >> 8) < prob) begin
        case (direction[v])
          DIR_REVERSE: step[v] = (step[v] + len - 1) % len;
          DIR_RANDOM:  step[v] = next_random() % len;
          default:     step[v] = (step[v] + 1) % len;
        endcase
      end
      return 1'b1;
    endfunction

    function void note_tick(input item_t t);
      res_t r;
      r.moved_a = advance_voice(0, t.edge_a, t.chance_a, t.length_shift_a);
      r.moved_b = advance_voice(1, t.edge_b, t.chance_b, t.length_shift_b);
      r.step_a  = STEP_W'(step[0]);
      r.step_b  = STEP_W'(step[1]);
      expected_steps.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [STEP_W-1:0] want,
                                input logic [STEP_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] word);
      res_t want;
      if (expected_steps.size() == 0) begin
        $error("result word %h arrived with nothing expected", word);
        mismatches++;
        return;
      end
      want = expected_steps.pop_front();
      compare_field("step_a", want.step_a, word[3:0]);
      compare_field("step_b", want.step_b, word[7:4]);
      compare_field("moved_a", STEP_W'(want.moved_a), STEP_W'(word[8]));
      compare_field("moved_b", STEP_W'(want.moved_b), STEP_W'(word[9]));
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [SEED_W-1:0]     cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bit                    quiet      = 1'b0;
  int unsigned           ready_hold = 0;
  step_scoreboard        sb;

  probabilistic_step_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver stalls in bursts of random length until the quiet tail
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold     = ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold     = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic item_t make_tick(input bit ea, input bit eb, input int ca,
                                      input int cb, input int la, input int lb);
    item_t t;
    t.edge_a         = ea;
    t.edge_b         = eb;
    t.chance_a       = CHANCE_W'(ca);
    t.chance_b       = CHANCE_W'(cb);
    t.length_shift_a = SHIFT_W'(la);
    t.length_shift_b = SHIFT_W'(lb);
    return t;
  endfunction

  function automatic int random_chance();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return ONE;
      2:       return -int'($urandom_range(1, ONE));
      3:       return int'($urandom_range(ONE + 1, 2 * ONE));
      4:       return int'($urandom());       // whole 27-bit field
      default: return int'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic int random_shift();
    case ($urandom_range(0, 7))
      0:       return int'($urandom());       // whole 7-bit field
      1:       return 0;
      2:       return -15;
      3:       return -int'($urandom_range(0, 32));
      4:       return int'($urandom_range(0, 32));
      default: return -int'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic item_t random_tick();
    return make_tick($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                     random_chance(), random_chance(), random_shift(), random_shift());
  endfunction

  // Called just after a falling edge; returns just after one.
  task automatic send_tick(input item_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t.length_shift_b, t.length_shift_a,
                      t.chance_b, t.chance_a, t.edge_b, t.edge_a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_tick(t);
    @(negedge clk_i);
  endtask

  task automatic drain(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_steps.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // leaves cfg_we_i high; the caller drops it
  task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [DIV_W-1:0] div_a, input logic [DIV_W-1:0] div_b,
                           input logic [DIR_W-1:0] dir_a, input logic [DIR_W-1:0] dir_b,
                           input bit load_seed, input logic [SEED_W-1:0] seed);
    drain(4);
    cfg_word(CFG_DIVIDER_A, SEED_W'(div_a));
    cfg_word(CFG_DIVIDER_B, SEED_W'(div_b));
    cfg_word(CFG_DIRECTION_A, SEED_W'(dir_a));
    cfg_word(CFG_DIRECTION_B, SEED_W'(dir_b));
    if (load_seed) cfg_word(CFG_RNG_SEED, seed);
    cfg_we_i <= 1'b0;
    repeat (PHASE_TICKS) send_tick(random_tick());
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed ticks under reset settings: forward, divide by one, seed one
    send_tick(make_tick(0, 0, ONE, ONE, 0, 0));
    send_tick(make_tick(1, 1, ONE, ONE, 0, 0));
    send_tick(make_tick(1, 1, 0, 0, 0, 0));
    send_tick(make_tick(1, 1, -ONE, 2 * ONE, 0, 0));
    send_tick(make_tick(1, 1, -(1 << 26), (1 << 26) - 1, 0, 0));
    send_tick(make_tick(1, 1, ONE - 1, 1, 0, 0));
    send_tick(make_tick(1, 0, ONE, ONE, -15, 0));
    send_tick(make_tick(0, 1, ONE, ONE, 0, -16));
    send_tick(make_tick(1, 1, ONE, ONE, -64, 63));
    send_tick(make_tick(1, 1, ONE, ONE, -32, 32));
    repeat (5) send_tick(make_tick(1, 1, ONE, ONE, 0, 0));
    // shorter length with the step already past it
    send_tick(make_tick(1, 1, ONE, ONE, -12, -12));
    send_tick(make_tick(1, 1, ONE, ONE, -1, -1));
    repeat (4) send_tick(make_tick(1, 1, ONE, ONE, -13, -13));

    // zero seed loads one; a high divider phase leaves counts above the next
    run_phase(5'd1, 5'd1, DIR_REVERSE, DIR_RANDOM, 1'b1, 32'd0);
    run_phase(5'd16, 5'd13, DIR_RANDOM, DIR_FORWARD, 1'b0, 32'd0);
    run_phase(5'd3, 5'd2, DIR_FORWARD, DIR_REVERSE, 1'b1, 32'hFFFF_FFFF);
    run_phase(5'd0, 5'd31, DIR_SPARE, DIR_RANDOM, 1'b0, 32'd0);
    run_phase(5'd17, 5'd5, DIR_RANDOM, DIR_RANDOM, 1'b1, $urandom());
    run_phase(5'd2, 5'd1, DIR_REVERSE, DIR_SPARE, 1'b0, 32'd0);
    quiet = 1'b1;
    run_phase(DIV_W'($urandom_range(0, 31)), DIV_W'($urandom_range(0, 31)),
              DIR_W'($urandom_range(0, 3)), DIR_W'($urandom_range(0, 3)),
              1'b1, $urandom());

    drain(100);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/psseq_pkg.sv
rtl/psseq_rem.sv
rtl/psseq_ctrl.sv
rtl/probabilistic_step_sequencer.sv
bench/probabilistic_step_sequencer_tb.sv
